@@ rtl/core/mrg_pkg.sv @@
// Shared constants and types for the merge sorter.
package mrg_pkg;

  localparam int MAX_ELEMENTS_DEF = 64;
  localparam int DATA_W           = 32;

  // one sorted result handed from the engine to the output register
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
  } mrg_result_t;

endpackage

@@ rtl/core/mrg_bank.sv @@
// Element memory: one write port, two registered read ports.
module mrg_bank
  import mrg_pkg::*;
#(
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ rtl/core/mrg_engine.sv @@
// Load / bottom-up merge / emit sequencer working across two memory banks.
module mrg_engine
  import mrg_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [DATA_W-1:0]                     in_value,
  input  logic                                  in_last,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output mrg_result_t                           res,
  output logic                                  we0,
  output logic                                  we1,
  output logic [$clog2(MAX_ELEMENTS)-1:0]       waddr,
  output logic [DATA_W-1:0]                     wdata,
  output logic [$clog2(MAX_ELEMENTS)-1:0]       raddr_a,
  output logic [$clog2(MAX_ELEMENTS)-1:0]       raddr_b,
  input  logic [DATA_W-1:0]                     rd0_a,
  input  logic [DATA_W-1:0]                     rd0_b,
  input  logic [DATA_W-1:0]                     rd1_a,
  input  logic [DATA_W-1:0]                     rd1_b
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int SW = CW + 2;

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_PRIME = 2'd1;
  localparam logic [1:0] ST_MERGE = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]    state, state_next;
  logic          src, src_next;        // bank holding the current runs
  logic [CW-1:0] cnt, cnt_next;        // fill count, then set size
  logic [SW-1:0] w, w_next;            // run width of this pass
  logic [CW-1:0] l, l_next, r, r_next;
  logic [CW-1:0] mid, mid_next, hi, hi_next;
  logic [CW-1:0] c, c_next;            // output position (merge and emit)

  logic signed [DATA_W-1:0] a, b;
  logic          take_left;
  logic          accept, fire;
  logic [CW-1:0] c_inc, cnt_inc;
  logic [SW-1:0] n_ext, sum_mid, sum_hi, p_hi;
  logic [CW-1:0] seg_mid, seg_hi, prime_mid, prime_hi;

  assign a = src ? rd1_a : rd0_a;
  assign b = src ? rd1_b : rd0_b;

  assign take_left = (l < mid) && ((r >= hi) || (a <= b));

  assign c_inc   = c + 1'b1;
  assign cnt_inc = cnt + 1'b1;
  assign n_ext   = SW'(cnt);

  // bounds of the next pair of runs, clipped to the set size
  assign sum_mid   = SW'(hi) + w;
  assign sum_hi    = SW'(hi) + (w << 1);
  assign p_hi      = w << 1;
  assign seg_mid   = (sum_mid > n_ext) ? cnt : sum_mid[CW-1:0];
  assign seg_hi    = (sum_hi > n_ext) ? cnt : sum_hi[CW-1:0];
  assign prime_mid = (w > n_ext) ? cnt : w[CW-1:0];
  assign prime_hi  = (p_hi > n_ext) ? cnt : p_hi[CW-1:0];

  assign in_ready  = (state == ST_LOAD);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state == ST_EMIT);
  assign res.value = a;
  assign res.last  = (c_inc == cnt);
  assign fire      = res_valid && res_ready;

  assign we0   = (accept) || ((state == ST_MERGE) && src);
  assign we1   = (state == ST_MERGE) && !src;
  assign waddr = (state == ST_LOAD) ? cnt[AW-1:0] : c[AW-1:0];
  assign wdata = (state == ST_LOAD) ? in_value : (take_left ? a : b);

  always_comb begin
    state_next = state;
    src_next   = src;
    cnt_next   = cnt;
    w_next     = w;
    l_next     = l;
    r_next     = r;
    mid_next   = mid;
    hi_next    = hi;
    c_next     = c;
    raddr_a    = '0;
    raddr_b    = '0;
    unique case (state)
      ST_LOAD: begin
        if (accept) begin
          cnt_next = cnt_inc;
          if (in_last || (cnt_inc == CW'(MAX_ELEMENTS))) begin
            w_next     = SW'(1);
            state_next = ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        // issue reads for the heads of the first run pair
        raddr_b = prime_mid[AW-1:0];
        c_next  = '0;
        if (w >= n_ext) begin
          state_next = ST_EMIT;
        end else begin
          l_next     = '0;
          r_next     = prime_mid;
          mid_next   = prime_mid;
          hi_next    = prime_hi;
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: begin
        c_next = c_inc;
        if (c_inc == hi) begin
          if (hi == cnt) begin
            src_next   = !src;
            w_next     = w << 1;
            state_next = ST_PRIME;
          end else begin
            l_next   = hi;
            r_next   = seg_mid;
            mid_next = seg_mid;
            hi_next  = seg_hi;
          end
        end else if (take_left) begin
          l_next = l + 1'b1;
        end else begin
          r_next = r + 1'b1;
        end
        // read next heads so data lines up with l/r next cycle
        raddr_a = l_next[AW-1:0];
        raddr_b = r_next[AW-1:0];
      end
      ST_EMIT: begin
        raddr_a = c[AW-1:0];
        if (fire) begin
          c_next  = c_inc;
          raddr_a = c_inc[AW-1:0];
          if (res.last) begin
            cnt_next   = '0;
            src_next   = 1'b0;
            state_next = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      src   <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      src   <= src_next;
      cnt   <= cnt_next;
    end
    w   <= w_next;
    l   <= l_next;
    r   <= r_next;
    mid <= mid_next;
    hi  <= hi_next;
    c   <= c_next;
  end

endmodule

@@ rtl/core/merge_sorter.sv @@
// Top level of the merge sorter: element banks, sequencer and output register.
//
//  channel   dir  transaction
//  s_axis    in   one element: tdata = value, tlast = last_item
//  m_axis    out  one sorted element: tdata = sorted_value, tlast = last_result
//
// Loading takes an element whenever one is offered (s_axis_tready high only while loading).
// Sorting a set of n takes ceil(log2 n) passes, each pass a merge of one
// element per cycle between the two banks.
// Results leave at one per cycle; a stalled m_axis holds the engine in place.
// rst is synchronous, active high; memory contents need no clearing.
module merge_sorter
  import mrg_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] value
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] sorted_value
  output logic              m_axis_tlast
);

  localparam int AW = $clog2(MAX_ELEMENTS);

  logic              we0, we1;
  logic [AW-1:0]     waddr, raddr_a, raddr_b;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
  logic              res_valid, res_ready;
  mrg_result_t       res;

  // bank 0 takes the load; passes ping-pong between the banks
  mrg_bank #(.ADDR_W(AW)) u_bank0 (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd0_a),
    .rdata_b (rd0_b)
  );

  mrg_bank #(.ADDR_W(AW)) u_bank1 (
    .clk     (clk),
    .we      (we1),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd1_a),
    .rdata_b (rd1_b)
  );

  mrg_engine #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_value  (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .we0       (we0),
    .we1       (we1),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b),
    .rd0_a     (rd0_a),
    .rd0_b     (rd0_b),
    .rd1_a     (rd1_a),
    .rd1_b     (rd1_b)
  );

  // output register: refills in the same cycle the held result is taken
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
    if (res_ready && res_valid) begin
      m_axis_tdata <= res.value;
      m_axis_tlast <= res.last;
    end
  end

endmodule
